@@ src/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// uer_pkg
// Shared widths, register indexes, reset values and structs of the
// ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // tick counter width, also the width of stamps and echo widths
  localparam int COUNT_BITS  = 20;
  localparam int PERIOD_BITS = 20;
  localparam int TIMEOUT_BITS = 20;
  localparam int TRIG_BITS   = 10;
  localparam int WIDTH_BITS  = 20;
  localparam int DIST_BITS   = 21;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [PERIOD_BITS-1:0]  PERIOD_RST  = PERIOD_BITS'(100000);
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = TIMEOUT_BITS'(40000);
  localparam logic [TRIG_BITS-1:0]    TRIG_RST    = TRIG_BITS'(20);

  // distance = (w * 17) / 10 = (w * 17 * ceil(2^28 / 10)) >> 28, exact for
  // w * 17 below 2^26
  localparam int DIST_SHIFT = 28;
  localparam int DIST_RECIP = (1 << DIST_SHIFT) / 10 + 1;
  localparam int DIST_MUL_BITS = 29;
  localparam logic [DIST_MUL_BITS-1:0] DIST_MUL = DIST_MUL_BITS'(17 * DIST_RECIP);
  localparam int DIST_PROD_BITS = WIDTH_BITS + DIST_MUL_BITS;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TRIGGER_PERIOD = 2'd0,
    CFG_ECHO_TIMEOUT   = 2'd1,
    CFG_TRIGGER_WIDTH  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0]  trigger_period;
    logic [TIMEOUT_BITS-1:0] echo_timeout;
    logic [TRIG_BITS-1:0]    trigger_width;
  } uer_cfg_t;

  // per-tick status flags
  typedef struct packed {
    logic trig;
    logic busy;
    logic done;
    logic timeout;
  } uer_flags_t;

endpackage

@@ src/uer_ctrl.sv @@
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: tick count, trigger start, edge handling and
// timeout, one tick per step, with the per-tick result registered.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              level,
  input  uer_pkg::uer_cfg_t                 cfg,
  output uer_pkg::uer_flags_t               flags,
  output logic [uer_pkg::WIDTH_BITS-1:0]    width
);
  import uer_pkg::*;

  logic [COUNT_BITS-1:0] elapsed_count;
  logic [COUNT_BITS-1:0] elapsed_count_next;
  logic                  measuring;
  logic                  measuring_next;
  logic                  awaiting_fall;
  logic                  awaiting_fall_next;
  logic                  previous_echo;
  logic [COUNT_BITS-1:0] rise_stamp;
  logic [COUNT_BITS-1:0] rise_stamp_next;
  logic [COUNT_BITS-1:0] held_width;
  logic [COUNT_BITS-1:0] held_width_next;
  uer_flags_t            flags_next;

  logic                  start;
  logic                  meas0;
  logic                  await0;
  logic [COUNT_BITS-1:0] cnt0;
  logic                  rising;
  logic                  falling;
  logic                  set_rise;
  logic                  meas1;

  // one tick of the sequencer
  always_comb begin
    start    = !measuring && (elapsed_count >= COUNT_BITS'(cfg.trigger_period));
    meas0    = measuring || start;
    await0   = start ? 1'b0 : awaiting_fall;
    cnt0     = start ? '0 : elapsed_count;
    rising   = level && !previous_echo;
    falling  = !level && previous_echo;

    flags_next.trig = meas0 && (cnt0 < COUNT_BITS'(cfg.trigger_width));
    flags_next.done = meas0 && await0 && falling;
    set_rise        = meas0 && !await0 && rising;
    meas1           = meas0 && !flags_next.done;
    flags_next.timeout = meas1 && (cnt0 >= COUNT_BITS'(cfg.echo_timeout));
    measuring_next  = meas1 && !flags_next.timeout;
    flags_next.busy = measuring_next;

    if (!measuring_next) begin
      awaiting_fall_next = 1'b0;
    end else if (set_rise) begin
      awaiting_fall_next = 1'b1;
    end else begin
      awaiting_fall_next = await0;
    end

    rise_stamp_next    = set_rise ? cnt0 : rise_stamp;
    held_width_next    = flags_next.done ? (cnt0 - rise_stamp) : held_width;
    elapsed_count_next = (cnt0 != COUNT_MAX) ? (cnt0 + 1'b1) : cnt0;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_count <= '0;
      measuring     <= 1'b0;
      awaiting_fall <= 1'b0;
      previous_echo <= 1'b0;
      rise_stamp    <= '0;
      held_width    <= '0;
    end else if (step) begin
      elapsed_count <= elapsed_count_next;
      measuring     <= measuring_next;
      awaiting_fall <= awaiting_fall_next;
      previous_echo <= level;
      rise_stamp    <= rise_stamp_next;
      held_width    <= held_width_next;
    end
  end

  // per-tick result register
  always_ff @(posedge clk) begin
    if (step) begin
      flags <= flags_next;
      width <= WIDTH_BITS'(held_width_next);
    end
  end

`ifndef SYNTHESIS
  a_idle_not_awaiting: assert property (@(posedge clk) disable iff (rst)
    !measuring |-> !awaiting_fall)
    else $error("awaiting fall while idle");

  a_stamp_le_count: assert property (@(posedge clk) disable iff (rst)
    awaiting_fall |-> (rise_stamp <= elapsed_count))
    else $error("rise stamp ahead of tick count");
`endif

endmodule

@@ src/uer_out.sv @@
// ----------------------------------------------------------------------------
// uer_out
// Output stage: distance from the echo width by a constant multiply and
// the result register toward the consumer.
// ----------------------------------------------------------------------------
module uer_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic                              s1_valid,
  input  uer_pkg::uer_flags_t               s1_flags,
  input  logic [uer_pkg::WIDTH_BITS-1:0]    s1_width,
  output logic                              out_valid,
  output logic                              trigger_level,
  output logic                              busy_res,
  output logic                              measure_done,
  output logic                              no_echo,
  output logic [uer_pkg::WIDTH_BITS-1:0]    echo_width,
  output logic [uer_pkg::DIST_BITS-1:0]     distance_centi_cm
);
  import uer_pkg::*;

  logic [DIST_PROD_BITS-1:0] prod;
  logic [DIST_BITS-1:0]      distance;

  // width * 1.7 truncated, by reciprocal multiply
  always_comb begin
    prod     = DIST_PROD_BITS'(s1_width) * DIST_PROD_BITS'(DIST_MUL);
    distance = prod[DIST_SHIFT +: DIST_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= s1_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load && s1_valid) begin
      trigger_level     <= s1_flags.trig;
      busy_res          <= s1_flags.busy;
      measure_done      <= s1_flags.done;
      no_echo           <= s1_flags.timeout;
      echo_width        <= s1_width;
      distance_centi_cm <= distance;
    end
  end

`ifndef SYNTHESIS
  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(measure_done && no_echo))
    else $error("done and no echo on the same tick");
`endif

endmodule

@@ src/ultrasonic_echo_ranger.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger generation and echo timing for an ultrasonic range sensor, one
// request per microsecond tick, one result per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        in         in_valid / in_stall   echo_level
//  out       out        out_valid / out_stall trigger_level, busy_res,
//                                             measure_done, no_echo,
//                                             echo_width, distance_centi_cm
//  cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A request passes the input register, sequencer register and output
//  register in turn; one request is taken every cycle while in_stall is low.
//  The distance multiply sits alone between the sequencer and output registers.
//  Each stage fills while the one ahead holds, so a stall on out reaches
//  in_stall only when all three stages are full.
//  Synchronous reset loads the register defaults and idles the sequencer;
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                echo_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                trigger_level,
  output logic                                busy_res,
  output logic                                measure_done,
  output logic                                no_echo,
  output logic [uer_pkg::WIDTH_BITS-1:0]      echo_width,
  output logic [uer_pkg::DIST_BITS-1:0]       distance_centi_cm,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [uer_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import uer_pkg::*;

  uer_cfg_t   cfg;
  logic       s0_valid;
  logic       s0_level;
  logic       s1_valid;
  uer_flags_t s1_flags;
  logic [WIDTH_BITS-1:0] s1_width;
  logic       en_out;
  logic       en_s1;
  logic       en_s0;
  logic       step;

  // stage enables, each stage loads when it is empty or the next one moves
  always_comb begin
    en_out   = !out_valid || !out_stall;
    en_s1    = !s1_valid || en_out;
    en_s0    = !s0_valid || en_s1;
    step     = s0_valid && en_s1;
    in_stall = !en_s0;
  end

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_period <= PERIOD_RST;
      cfg.echo_timeout   <= TIMEOUT_RST;
      cfg.trigger_width  <= TRIG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIGGER_PERIOD: cfg.trigger_period <= PERIOD_BITS'(cfg_data);
        CFG_ECHO_TIMEOUT:   cfg.echo_timeout   <= TIMEOUT_BITS'(cfg_data);
        CFG_TRIGGER_WIDTH:  cfg.trigger_width  <= cfg_data[TRIG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en_s0) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s0 && in_valid) begin
      s0_level <= echo_level;
    end
  end

  // sequencer stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en_s1) begin
      s1_valid <= s0_valid;
    end
  end

  uer_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .level (s0_level),
    .cfg   (cfg),
    .flags (s1_flags),
    .width (s1_width)
  );

  uer_out u_out (
    .clk               (clk),
    .rst               (rst),
    .load              (en_out),
    .s1_valid          (s1_valid),
    .s1_flags          (s1_flags),
    .s1_width          (s1_width),
    .out_valid         (out_valid),
    .trigger_level     (trigger_level),
    .busy_res          (busy_res),
    .measure_done      (measure_done),
    .no_echo           (no_echo),
    .echo_width        (echo_width),
    .distance_centi_cm (distance_centi_cm)
  );

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s0_valid && s1_valid && out_valid))
    else $error("input stalled with a free stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !en_s1) |=> (s1_valid && $stable(s1_flags) && $stable(s1_width)))
    else $error("sequencer result lost while output held");
`endif

endmodule
